FILE: hdl/ntfs_pkg.sv
// shared types, constants and helpers for the noise texture fill and sample block
package ntfs_pkg;

    localparam int DEF_TEXTURE_SIDE = 32;
    localparam int DEF_SLOT_COUNT   = 16;

    localparam int DIVIDEND_W     = 32;
    localparam int MODULUS_W      = 9;
    localparam int REM_CNT_W      = 5;
    localparam int FRAC_W         = 16;
    localparam int COORD_W        = 24;
    localparam int CHAN_W         = 9;
    localparam int SPREAD_W       = 8;
    localparam int TEXEL_W        = 24;
    localparam int CFG_SLOT_W     = 4;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 24;
    localparam int IN_SLOT_W      = 5;
    localparam int SLOT_CMP_W     = 7;

    localparam logic [31:0] LCG_SEED_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_SEED_ADD = 32'd12345;
    localparam logic [31:0] LCG_MUL      = 32'd1664525;
    localparam logic [31:0] LCG_ADD      = 32'd1013904223;
    localparam logic [7:0]  CHANNEL_MAX  = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_SLOT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_SLOT  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_U     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_V     = 8'd3;

    localparam logic FUNC_FILL   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL_STEP,
        S_FILL_DIV,
        S_SAMP_IDX,
        S_SAMP_ADDR,
        S_SAMP_READ,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

    function automatic logic [7:0] clamp_channel(input logic signed [10:0] c);
        logic [7:0] r;
        if (c < 0)
            r = 8'd0;
        else if (c > 11'sd255)
            r = CHANNEL_MAX;
        else
            r = c[7:0];
        return r;
    endfunction

endpackage

FILE: hdl/ntfs_rem_unit.sv
// restoring remainder unit, one quotient bit per cycle
module ntfs_rem_unit
    import ntfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [MODULUS_W-1:0]  modulus,
    output rem_status_t           status,
    output logic [MODULUS_W-1:0]  remainder
);

    logic [DIVIDEND_W-1:0] shift_reg;
    logic [MODULUS_W-1:0]  rem_reg;
    logic [REM_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [MODULUS_W:0]    trial;
    logic [MODULUS_W:0]    diff;

    assign trial = {rem_reg, shift_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, modulus};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == REM_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, modulus})
                rem_reg <= diff[MODULUS_W-1:0];
            else
                rem_reg <= trial[MODULUS_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

FILE: hdl/ntfs_atlas_mem.sv
// texture atlas storage, one write and one registered read port
module ntfs_atlas_mem
    import ntfs_pkg::*;
#(
    parameter int DEPTH  = DEF_SLOT_COUNT * DEF_TEXTURE_SIDE * DEF_TEXTURE_SIDE,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [TEXEL_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [TEXEL_W-1:0] rd_data
);

    logic [TEXEL_W-1:0] mem [DEPTH];
    logic [TEXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/noise_texture_fill_and_sample_top.sv
// top level of the noise texture fill and sample block: sequencer, registers, output stage
//
// A fill item walks every texel of its slot; per texel one step advances the
// 32-bit LCG, the restoring remainder unit (one bit per cycle) reduces the
// state modulo 2*spread+1, and a last step clamps and stores the texel. A
// sample item passes through accept, coordinate wrap, address, atlas read and
// result. One item is in work at a time; in_stall is high from acceptance
// until the result moves into the output register, which can hold a finished
// result while the next item is accepted.
// The atlas has no clearing pass; sample only slots that were filled.
module noise_texture_fill_and_sample_top
    import ntfs_pkg::*;
#(
    parameter int TEXTURE_SIDE = DEF_TEXTURE_SIDE,
    parameter int SLOT_COUNT   = DEF_SLOT_COUNT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic [IN_SLOT_W-1:0]     slot,
    input  logic [CHAN_W-1:0]        base_red,
    input  logic [CHAN_W-1:0]        base_green,
    input  logic [CHAN_W-1:0]        base_blue,
    input  logic [SPREAD_W-1:0]      spread,
    input  logic signed [COORD_W-1:0] coord_u,
    input  logic signed [COORD_W-1:0] coord_v,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [TEXEL_W-1:0]       texel,
    output logic                     fill_done,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int TPS     = TEXTURE_SIDE * TEXTURE_SIDE;
    localparam int DEPTH   = SLOT_COUNT * TPS;
    localparam int AW      = $clog2(DEPTH);
    localparam int IW      = $clog2(TPS);
    localparam int XW      = $clog2(TEXTURE_SIDE);
    localparam int SIDE_W  = $clog2(TEXTURE_SIDE + 1);
    localparam int PW      = FRAC_W + SIDE_W;
    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [AW-1:0] TPS_A  = AW'(TPS);
    localparam logic [AW-1:0] SIDE_A = AW'(TEXTURE_SIDE);
    localparam logic [PW-1:0] SIDE_P = PW'(TEXTURE_SIDE);

    state_t state_reg, state_next;

    logic [CFG_SLOT_W-1:0] default_slot_reg;
    logic [CFG_SLOT_W-1:0] scroll_slot_reg;
    logic [FRAC_W-1:0]     offset_u_reg;
    logic [FRAC_W-1:0]     offset_v_reg;

    logic                  func_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [CHAN_W-1:0]     red_reg;
    logic [CHAN_W-1:0]     green_reg;
    logic [CHAN_W-1:0]     blue_reg;
    logic [SPREAD_W-1:0]   spread_reg;
    logic [FRAC_W-1:0]     frac_u_reg;
    logic [FRAC_W-1:0]     frac_v_reg;
    logic [XW-1:0]         x_reg;
    logic [XW-1:0]         y_reg;
    logic [31:0]           lcg_reg;
    logic [AW-1:0]         addr_reg;
    logic [IW-1:0]         idx_reg;

    logic                  out_valid_reg;
    logic [TEXEL_W-1:0]    texel_reg;
    logic                  fill_done_reg;

    logic                  accept;
    logic                  rem_start;
    logic                  mem_we;
    logic                  mem_re;
    logic                  out_load;
    logic                  last_texel;
    logic                  out_free;

    logic [SLOT_CMP_W-1:0] def_sat;
    logic [SLOT_CMP_W-1:0] eff_slot;
    logic                  scroll_hit;
    logic [31:0]           lcg_step;
    logic [PW-1:0]         prod_u;
    logic [PW-1:0]         prod_v;

    rem_status_t           rem_status;
    logic [MODULUS_W-1:0]  rem_value;
    logic [MODULUS_W-1:0]  modulus;
    logic signed [10:0]    noise;
    logic [TEXEL_W-1:0]    fill_texel;
    logic [TEXEL_W-1:0]    rd_data;

    assign accept     = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || !out_stall;
    assign last_texel = (idx_reg == IW'(TPS - 1));

    assign def_sat  = (SLOT_CMP_W'(default_slot_reg) >= SLOT_CMP_W'(SLOT_COUNT)) ?
                      SLOT_CMP_W'(SLOT_COUNT - 1) : SLOT_CMP_W'(default_slot_reg);
    assign eff_slot = (SLOT_CMP_W'(slot) < SLOT_CMP_W'(SLOT_COUNT)) ?
                      SLOT_CMP_W'(slot) : def_sat;
    assign scroll_hit = (eff_slot == SLOT_CMP_W'(scroll_slot_reg));

    assign lcg_step = lcg_reg * LCG_MUL + LCG_ADD;
    assign modulus  = {spread_reg, 1'b1};
    assign noise    = $signed({2'b00, rem_value}) - $signed({3'b000, spread_reg});

    assign fill_texel = {clamp_channel($signed({2'b00, red_reg}) + noise),
                         clamp_channel($signed({2'b00, green_reg}) + noise),
                         clamp_channel($signed({2'b00, blue_reg}) + noise)};

    assign prod_u = PW'(frac_u_reg) * SIDE_P;
    assign prod_v = PW'(frac_v_reg) * SIDE_P;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (func == FUNC_FILL) ? S_FILL_STEP : S_SAMP_IDX;
            end
            S_FILL_STEP:
                state_next = S_FILL_DIV;
            S_FILL_DIV:
            begin
                if (rem_status.done)
                    state_next = last_texel ? S_RESULT : S_FILL_STEP;
            end
            S_SAMP_IDX:
                state_next = S_SAMP_ADDR;
            S_SAMP_ADDR:
                state_next = S_SAMP_READ;
            S_SAMP_READ:
                state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        rem_start = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:      in_stall  = 1'b0;
            S_FILL_STEP: rem_start = 1'b1;
            S_FILL_DIV:  mem_we    = rem_status.done;
            S_SAMP_READ: mem_re    = 1'b1;
            S_RESULT:    out_load  = out_free;
            default:     in_stall  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_slot_reg <= 4'd1;
            scroll_slot_reg  <= 4'd5;
            offset_u_reg     <= '0;
            offset_v_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEFAULT_SLOT: default_slot_reg <= cfg_data[CFG_SLOT_W-1:0];
                CFG_SCROLL_SLOT:  scroll_slot_reg  <= cfg_data[CFG_SLOT_W-1:0];
                CFG_OFFSET_U:     offset_u_reg     <= cfg_data[FRAC_W-1:0];
                CFG_OFFSET_V:     offset_v_reg     <= cfg_data[FRAC_W-1:0];
                default:          ;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            slot_reg   <= SLOT_W'(eff_slot);
            red_reg    <= base_red;
            green_reg  <= base_green;
            blue_reg   <= base_blue;
            spread_reg <= spread;
            frac_u_reg <= coord_u[FRAC_W-1:0] + (scroll_hit ? offset_u_reg : '0);
            frac_v_reg <= coord_v[FRAC_W-1:0] + (scroll_hit ? offset_v_reg : '0);
            lcg_reg    <= 32'(eff_slot) * LCG_SEED_MUL + LCG_SEED_ADD;
            addr_reg   <= AW'(eff_slot) * TPS_A;
            idx_reg    <= '0;
        end
        if (rem_start)
            lcg_reg <= lcg_step;
        if (mem_we)
        begin
            addr_reg <= addr_reg + 1'b1;
            idx_reg  <= idx_reg + 1'b1;
        end
        if (state_reg == S_SAMP_IDX)
        begin
            x_reg <= prod_u[FRAC_W +: XW];
            y_reg <= prod_v[FRAC_W +: XW];
        end
        if (state_reg == S_SAMP_ADDR)
            addr_reg <= AW'(slot_reg) * TPS_A + AW'(y_reg) * SIDE_A + AW'(x_reg);
    end

    ntfs_rem_unit u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (lcg_step),
        .modulus   (modulus),
        .status    (rem_status),
        .remainder (rem_value)
    );

    ntfs_atlas_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_atlas
    (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (addr_reg),
        .wr_data (fill_texel),
        .rd_en   (mem_re),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            fill_done_reg <= (func_reg == FUNC_FILL);
            texel_reg     <= (func_reg == FUNC_FILL) ? '0 : rd_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign texel     = texel_reg;
    assign fill_done = fill_done_reg;

    // handshake checks
    ap_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall);
    ap_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid);
    ap_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(texel) && $stable(fill_done));

endmodule

FILE: bench/noise_texture_fill_and_sample_top_tb.sv
// self-checking testbench for the noise texture fill and sample top level
`timescale 1ns / 100ps

module noise_texture_fill_and_sample_top_tb;
    import ntfs_pkg::*;

    localparam int SIDE        = 32;
    localparam int SLOTS       = 16;
    localparam int TEXELS      = SIDE * SIDE;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int FILL_BUDGET = 10;

    localparam logic [31:0] SEED_MUL = 32'd1103515245;
    localparam logic [31:0] SEED_ADD = 32'd12345;
    localparam logic [31:0] STEP_MUL = 32'd1664525;
    localparam logic [31:0] STEP_ADD = 32'd1013904223;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 8'd255;

    typedef struct packed {
        logic                 func;
        logic [IN_SLOT_W-1:0] slot;
        logic [CHAN_W-1:0]    red;
        logic [CHAN_W-1:0]    green;
        logic [CHAN_W-1:0]    blue;
        logic [SPREAD_W-1:0]  spread;
        logic [COORD_W-1:0]   u;
        logic [COORD_W-1:0]   v;
    } item_t;

    typedef struct packed {
        logic [TEXEL_W-1:0] texel;
        logic               done;
    } result_t;

    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t res;
    } row_t;

    logic                   clk;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic                   func       = FUNC_FILL;
    logic [IN_SLOT_W-1:0]   slot       = '0;
    logic [CHAN_W-1:0]      base_red   = '0;
    logic [CHAN_W-1:0]      base_green = '0;
    logic [CHAN_W-1:0]      base_blue  = '0;
    logic [SPREAD_W-1:0]    spread     = '0;
    logic [COORD_W-1:0]     coord_u    = '0;
    logic [COORD_W-1:0]     coord_v    = '0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic [TEXEL_W-1:0]     texel;
    logic                   fill_done;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    logic [TEXEL_W-1:0]    atlas_mem [0:SLOTS*TEXELS-1];
    bit                    slot_filled [0:SLOTS-1];
    logic [CFG_SLOT_W-1:0] dflt_slot_m   = 4'd1;
    logic [CFG_SLOT_W-1:0] scroll_slot_m = 4'd5;
    logic [COORD_W-1:0]    off_u_m       = '0;
    logic [COORD_W-1:0]    off_v_m       = '0;

    result_t texel_q [$];
    row_t    dir_rows [0:13];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      fills_left     = FILL_BUDGET;
    bit      sender_idle    = 1'b1;
    bit      recv_idle      = 1'b1;
    bit      hold_req       = 1'b0;

    noise_texture_fill_and_sample_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .slot       (slot),
        .base_red   (base_red),
        .base_green (base_green),
        .base_blue  (base_blue),
        .spread     (spread),
        .coord_u    (coord_u),
        .coord_v    (coord_v),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .texel      (texel),
        .fill_done  (fill_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] clamp8(input int c);
        if (c < 0)
            return 8'd0;
        if (c > 255)
            return 8'd255;
        return c[7:0];
    endfunction

    function automatic logic [CFG_SLOT_W-1:0] eff_slot(input logic [IN_SLOT_W-1:0] s);
        if (s < SLOTS)
            return s[CFG_SLOT_W-1:0];
        return dflt_slot_m;
    endfunction

    // fills update the atlas copy, samples read it
    function automatic result_t texel_of_item(input item_t it);
        result_t             r;
        logic [CFG_SLOT_W-1:0] es;
        logic [31:0]         lcg;
        logic [31:0]         modv;
        logic [COORD_W-1:0]  u;
        logic [COORD_W-1:0]  v;
        int                  noise;
        int                  base_idx;
        int                  x;
        int                  y;
        int                  i;
        es = eff_slot(it.slot);
        if (it.func == FUNC_FILL)
        begin
            lcg = {28'd0, es} * SEED_MUL + SEED_ADD;
            modv = {23'd0, it.spread, 1'b0} + 32'd1;
            base_idx = int'(es) * TEXELS;
            for (i = 0; i < TEXELS; i++)
            begin
                lcg = lcg * STEP_MUL + STEP_ADD;
                noise = int'(lcg % modv) - int'(it.spread);
                atlas_mem[base_idx + i] = {clamp8(int'(it.red) + noise),
                                           clamp8(int'(it.green) + noise),
                                           clamp8(int'(it.blue) + noise)};
            end
            slot_filled[es] = 1'b1;
            r.texel = '0;
            r.done = 1'b1;
        end
        else
        begin
            u = it.u;
            v = it.v;
            if (es == scroll_slot_m)
            begin
                u = u + off_u_m;
                v = v + off_v_m;
            end
            x = (int'(u[FRAC_W-1:0]) * SIDE) >> FRAC_W;
            y = (int'(v[FRAC_W-1:0]) * SIDE) >> FRAC_W;
            r.texel = atlas_mem[int'(es) * TEXELS + y * SIDE + x];
            r.done = 1'b0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic send_item(input item_t it, input logic typed, input result_t typed_res);
        result_t want;
        @(negedge clk);
        while (sender_idle && $urandom_range(0, 99) < 21)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        func       = it.func;
        slot       = it.slot;
        base_red   = it.red;
        base_green = it.green;
        base_blue  = it.blue;
        spread     = it.spread;
        coord_u    = it.u;
        coord_v    = it.v;
        in_valid   = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = texel_of_item(it);
        if (typed)
            want = typed_res;
        texel_q.push_back(want);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DEFAULT_SLOT: dflt_slot_m = data[CFG_SLOT_W-1:0];
            CFG_SCROLL_SLOT:  scroll_slot_m = data[CFG_SLOT_W-1:0];
            CFG_OFFSET_U:     off_u_m = data;
            CFG_OFFSET_V:     off_v_m = data;
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (texel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_random(input int count, input int samples_first);
        item_t it;
        int    k;
        int    pick;
        for (k = 0; k < count; k++)
        begin
            it.func = FUNC_SAMPLE;
            if (k >= samples_first && fills_left > 0 && $urandom_range(0, 11) == 0)
                it.func = FUNC_FILL;
            it.slot   = IN_SLOT_W'($urandom_range(0, 31));
            it.red    = CHAN_W'($urandom_range(0, 511));
            it.green  = CHAN_W'($urandom_range(0, 511));
            it.blue   = CHAN_W'($urandom_range(0, 511));
            it.spread = SPREAD_W'($urandom_range(0, 255));
            it.u      = COORD_W'($urandom());
            it.v      = COORD_W'($urandom());
            if (it.func == FUNC_FILL)
                fills_left--;
            else if (!slot_filled[eff_slot(it.slot)])
            begin
                do
                    pick = $urandom_range(0, SLOTS - 1);
                while (!slot_filled[pick]);
                it.slot = IN_SLOT_W'(pick);
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // receiver side: random stalls plus one long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = recv_idle && ($urandom_range(0, 99) < 21);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (out_valid && !out_stall)
        begin
            if (texel_q.size() == 0)
                flag_mismatch($sformatf("result with none pending: texel %h fill_done %b",
                                        texel, fill_done));
            else
            begin
                want = texel_q.pop_front();
                if (texel !== want.texel)
                    flag_mismatch($sformatf("texel got %h want %h", texel, want.texel));
                if (fill_done !== want.done)
                    flag_mismatch($sformatf("fill_done got %b want %b", fill_done, want.done));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("noise_texture_fill_and_sample_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        for (n = 0; n < SLOTS; n++)
            slot_filled[n] = 1'b0;
        dir_rows = '{
            '{'{FUNC_FILL,   5'd0,  9'd0,   9'd0,   9'd0,   8'd0,   24'h000000, 24'h000000},
              1'b1, '{24'h000000, 1'b1}},
            '{'{FUNC_FILL,   5'd15, 9'd511, 9'd256, 9'd300, 8'd0,   24'hFFFFFF, 24'h7FFFFF},
              1'b1, '{24'h000000, 1'b1}},
            '{'{FUNC_FILL,   5'd31, 9'd128, 9'd200, 9'd50,  8'd255, 24'h800000, 24'h000000},
              1'b1, '{24'h000000, 1'b1}},
            '{'{FUNC_FILL,   5'd5,  9'd300, 9'd128, 9'd0,   8'd0,   24'h123456, 24'h654321},
              1'b1, '{24'h000000, 1'b1}},
            '{'{FUNC_FILL,   5'd2,  9'd0,   9'd0,   9'd511, 8'd255, 24'h000000, 24'hFFFFFF},
              1'b1, '{24'h000000, 1'b1}},
            '{'{FUNC_SAMPLE, 5'd0,  9'd0,   9'd0,   9'd0,   8'd0,   24'h000000, 24'h000000},
              1'b1, '{24'h000000, 1'b0}},
            '{'{FUNC_SAMPLE, 5'd15, 9'd511, 9'd511, 9'd511, 8'd255, 24'hFFFFFF, 24'h800000},
              1'b1, '{24'hFFFFFF, 1'b0}},
            '{'{FUNC_SAMPLE, 5'd15, 9'd0,   9'd0,   9'd0,   8'd0,   24'h7FFFFF, 24'h7FFFFF},
              1'b1, '{24'hFFFFFF, 1'b0}},
            '{'{FUNC_SAMPLE, 5'd5,  9'd0,   9'd0,   9'd0,   8'd0,   24'h00FFFF, 24'h000000},
              1'b1, '{24'hFF8000, 1'b0}},
            '{'{FUNC_SAMPLE, 5'd31, 9'd0,   9'd0,   9'd0,   8'd0,   24'h7FFFFF, 24'h800000},
              1'b0, '{24'h000000, 1'b0}},
            '{'{FUNC_SAMPLE, 5'd16, 9'd0,   9'd0,   9'd0,   8'd0,   24'h800000, 24'hFFFFFF},
              1'b0, '{24'h000000, 1'b0}},
            '{'{FUNC_SAMPLE, 5'd1,  9'd0,   9'd0,   9'd0,   8'd0,   24'h008000, 24'h00C000},
              1'b0, '{24'h000000, 1'b0}},
            '{'{FUNC_SAMPLE, 5'd2,  9'd0,   9'd0,   9'd0,   8'd0,   24'h000000, 24'h00FFFF},
              1'b0, '{24'h000000, 1'b0}},
            '{'{FUNC_SAMPLE, 5'd2,  9'd0,   9'd0,   9'd0,   8'd0,   24'h00FFFF, 24'h000000},
              1'b0, '{24'h000000, 1'b0}}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values
        for (n = 0; n < 14; n++)
            send_item(dir_rows[n].it, dir_rows[n].typed, dir_rows[n].res);
        wait_drained();

        // extreme offsets, default slot at the top, long receiver hold-off
        cfg_write(CFG_DEFAULT_SLOT, 24'hFFFFFF);
        cfg_write(CFG_SCROLL_SLOT, 24'hABCDE1);
        cfg_write(CFG_OFFSET_U, 24'h7FFFFF);
        cfg_write(CFG_OFFSET_V, 24'h800000);
        cfg_write(CFG_UNUSED, 24'h123456);
        @(posedge clk);
        hold_req = 1'b1;
        run_random(32, 12);
        wait_drained();

        // no idling on either side
        sender_idle = 1'b0;
        recv_idle = 1'b0;
        cfg_write(CFG_DEFAULT_SLOT, 24'h000000);
        cfg_write(CFG_SCROLL_SLOT, 24'h000000);
        cfg_write(CFG_OFFSET_U, CFG_DATA_W'($urandom()));
        cfg_write(CFG_OFFSET_V, CFG_DATA_W'($urandom()));
        run_random(32, 0);
        wait_drained();

        sender_idle = 1'b1;
        recv_idle = 1'b1;
        cfg_write(CFG_DEFAULT_SLOT, 24'h000002);
        cfg_write(CFG_SCROLL_SLOT, 24'h00000F);
        cfg_write(CFG_OFFSET_U, 24'hFFFFFF);
        cfg_write(CFG_OFFSET_V, 24'h000000);
        run_random(16, 0);
        wait_drained();
        run_random(16, 0);
        wait_drained();

        if (mismatch_count == 0)
            $display("noise_texture_fill_and_sample_top_tb: PASS");
        else
            $display("noise_texture_fill_and_sample_top_tb: FAIL");
        $finish;
    end

endmodule
